// File: sv/rlpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rlpg_pkg;

  localparam int ChanW = 8;
  // r*r + g*g + b*b peaks at 3*255*255, which fits in 18 bits
  localparam int SumW  = 18;
  // 3*cand*cand for a trial bit may overshoot the sum, so compare wider
  localparam int CandW = 20;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic [ChanW-1:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic [ChanW-1:0] alpha_out;
  } pixel_out_t;

  typedef struct packed {
    pixel_in_t         pix;
    logic [SumW-1:0]   sum;
    logic [ChanW-1:0]  gray;
    logic [SumW-1:0]   gray_sq3;
  } stage_t;

endpackage

`default_nettype wire

// File: sv/rgb_length_preserving_grayscale_core.sv
// Length-preserving grayscale for RGBA pixels, 8 bits per channel.
// Input beats arrive on in_valid/in_ready/in_pixel, results leave on
// out_valid/out_ready/out_pixel. The gray level is the largest g with
// 3*g*g <= r*r + g*g + b*b, written to all three colour channels; alpha is
// copied. A pixel with alpha zero leaves with all channels unchanged.
// Pipeline: one stage of three 8x8 squarers, one stage summing them, then
// eight stages that each settle one bit of the gray level (add and compare
// against the running 3*g*g), most significant bit first.
// Each accepted beat passes through the squarer stage, the sum stage and the
// eight bit stages before out_valid shows it; one pixel per cycle is sustained
// while out_ready stays high.
// Each stage has its own valid bit and moves whenever the stage after it
// is empty or moving, so bubbles close up when the receiver stalls and a
// held result never blocks intake while earlier stages have room.
// in_ready drops only once every stage holds a beat.
// Reset clears all valid bits; the pipeline is empty and in_ready is high
// after reset.
`timescale 1ns / 1ps
`default_nettype none

module rgb_length_preserving_grayscale_core
  import rlpg_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  pixel_in_t   in_pixel,
  output logic        out_valid,
  input  wire         out_ready,
  output pixel_out_t  out_pixel
);

  localparam int BitStages = ChanW;
  localparam int Stages    = BitStages + 2;
  localparam int Last      = Stages - 1;

  logic [Stages-1:0] valid;
  logic [Stages-1:0] adv;
  stage_t            stage [Stages];

  logic [2*ChanW-1:0] sq_r;
  logic [2*ChanW-1:0] sq_g;
  logic [2*ChanW-1:0] sq_b;

  // stage may load when empty or when its beat moves on
  always_comb begin
    adv[Last] = !valid[Last] || out_ready;
    for (int i = Last - 1; i >= 0; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (adv[0]) begin
      valid[0] <= in_valid;
    end
    if (adv[0]) begin
      stage[0].pix      <= in_pixel;
      stage[0].sum      <= '0;
      stage[0].gray     <= '0;
      stage[0].gray_sq3 <= '0;
      sq_r <= in_pixel.red_in * in_pixel.red_in;
      sq_g <= in_pixel.green_in * in_pixel.green_in;
      sq_b <= in_pixel.blue_in * in_pixel.blue_in;
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[1] <= 1'b0;
    end else if (adv[1]) begin
      valid[1] <= valid[0];
    end
    if (adv[1]) begin
      stage[1].pix      <= stage[0].pix;
      stage[1].sum      <= SumW'(sq_r) + SumW'(sq_g) + SumW'(sq_b);
      stage[1].gray     <= '0;
      stage[1].gray_sq3 <= '0;
    end
  end

  // one gray bit per stage: 3*(g+2^k)^2 = 3g^2 + 3*g*2^(k+1) + 3*4^k
  for (genvar j = 0; j < BitStages; j++) begin : g_bit
    localparam int K   = BitStages - 1 - j;
    localparam int Cur = j + 2;
    localparam int Prv = j + 1;
    localparam logic [CandW-1:0] BitSq3 = CandW'(3) << (2 * K);

    logic [CandW-1:0] wide_g;
    logic [CandW-1:0] cross3;
    logic [CandW-1:0] cand3;
    logic             take;

    always_comb begin
      wide_g = CandW'(stage[Prv].gray) << (K + 1);
      cross3 = wide_g + (wide_g << 1);
      cand3  = CandW'(stage[Prv].gray_sq3) + cross3 + BitSq3;
      take   = cand3 <= CandW'(stage[Prv].sum);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[Cur] <= 1'b0;
      end else if (adv[Cur]) begin
        valid[Cur] <= valid[Prv];
      end
      if (adv[Cur]) begin
        stage[Cur].pix <= stage[Prv].pix;
        stage[Cur].sum <= stage[Prv].sum;
        if (take) begin
          stage[Cur].gray     <= stage[Prv].gray | (ChanW'(1) << K);
          stage[Cur].gray_sq3 <= cand3[SumW-1:0];
        end else begin
          stage[Cur].gray     <= stage[Prv].gray;
          stage[Cur].gray_sq3 <= stage[Prv].gray_sq3;
        end
      end
    end
  end

  assign out_valid = valid[Last];

  always_comb begin
    out_pixel.alpha_out = stage[Last].pix.alpha_in;
    if (stage[Last].pix.alpha_in == '0) begin
      out_pixel.red_out   = stage[Last].pix.red_in;
      out_pixel.green_out = stage[Last].pix.green_in;
      out_pixel.blue_out  = stage[Last].pix.blue_in;
    end else begin
      out_pixel.red_out   = stage[Last].gray;
      out_pixel.green_out = stage[Last].gray;
      out_pixel.blue_out  = stage[Last].gray;
    end
  end

endmodule

`default_nettype wire
